// ----- src/eust_pkg.sv -----
// Shared types, constants and the month-length table for the summer-time shift.
// No dependencies; every module of the block imports it.
package eust_pkg;

    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned CENT_W  = 6;
    localparam int unsigned SUM_W   = 9;

    // Reciprocal multipliers: y/100 = (y*5243)>>19, s/7 = (s*293)>>11 over the used ranges.
    localparam int unsigned DIV100_MUL   = 5243;
    localparam int unsigned DIV100_SHIFT = 19;
    localparam int unsigned DIV7_MUL     = 293;
    localparam int unsigned DIV7_SHIFT   = 11;

    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;

    // Zeller month terms (13*(m+1))/5 for March and October, plus day 31.
    localparam logic [SUM_W-1:0] ZEL_MAR   = 9'd10;
    localparam logic [SUM_W-1:0] ZEL_OCT   = 9'd28;
    localparam logic [SUM_W-1:0] LAST_DAY  = 9'd31;
    localparam logic [DAY_W-1:0] MONTH_END = 5'd31;

    localparam logic [HOUR_W-1:0] HOUR_MAX     = 5'd23;
    localparam logic [HOUR_W-1:0] HOUR_SPRING  = 5'd2;
    localparam logic [HOUR_W-1:0] HOUR_AUTUMN  = 5'd3;

    typedef struct packed {
        logic               action;
        logic [YEAR_W-1:0]  in_year;
        logic [MONTH_W-1:0] in_month;
        logic [DAY_W-1:0]   in_day;
        logic [HOUR_W-1:0]  in_hour;
    } item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  out_year;
        logic [MONTH_W-1:0] out_month;
        logic [DAY_W-1:0]   out_day;
        logic [HOUR_W-1:0]  out_hour;
        logic               summer_time;
    } result_t;

    typedef struct packed {
        item_t             item;
        logic [CENT_W-1:0] cent;
    } cen_t;

    typedef struct packed {
        item_t            item;
        logic [DAY_W-1:0] last_sun;
    } sun_t;

    // Days per month, February without leap day; codes outside 1..12 read 31.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                    len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- src/eust_century.sv -----
// First pipeline stage: splits off the century of the year by reciprocal multiply.
// Depends on eust_pkg.
module eust_century (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_stall,
    input  eust_pkg::item_t up_item,
    output logic          dn_valid,
    input  logic          dn_stall,
    output eust_pkg::cen_t dn_data
);
    import eust_pkg::*;

    localparam int unsigned PROD_W = YEAR_W + 13;

    logic              valid_reg;
    cen_t              data_reg;
    cen_t              data_next;
    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(up_item.in_year) * PROD_W'(DIV100_MUL);

    always_comb
    begin
        data_next.item = up_item;
        data_next.cent = prod[DIV100_SHIFT +: CENT_W];
    end

    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;
endmodule

// ----- src/eust_lastsun.sv -----
// Second and third pipeline stages: Zeller sum, then mod 7 and the last-Sunday date.
// Depends on eust_pkg.
module eust_lastsun (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_stall,
    input  eust_pkg::cen_t up_data,
    output logic           dn_valid,
    input  logic           dn_stall,
    output eust_pkg::sun_t dn_data
);
    import eust_pkg::*;

    localparam int unsigned REM_W  = 7;
    localparam int unsigned PROD_W = 2 * SUM_W;
    localparam int unsigned QUO_W  = PROD_W - DIV7_SHIFT;

    // stage B: weekday sum
    logic              b_valid_reg;
    item_t             b_item_reg;
    logic [SUM_W-1:0]  b_sum_reg;
    logic [SUM_W-1:0]  b_sum_next;
    logic              b_stall;
    logic [YEAR_W-1:0] cent100;
    logic [YEAR_W-1:0] yrem_w;
    logic [REM_W-1:0]  yrem;
    logic [SUM_W-1:0]  zel_m;

    // stage C: last Sunday
    logic              c_valid_reg;
    sun_t              c_data_reg;
    sun_t              c_data_next;
    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0]  quo;
    logic [SUM_W-1:0]  quo7;
    logic [SUM_W-1:0]  rem_w;
    logic [2:0]        rem;
    logic [2:0]        wday;

    always_comb
    begin
        cent100 = (YEAR_W'(up_data.cent) << 6) + (YEAR_W'(up_data.cent) << 5)
                + (YEAR_W'(up_data.cent) << 2);
        yrem_w  = up_data.item.in_year - cent100;
        yrem    = yrem_w[REM_W-1:0];
        zel_m   = (up_data.item.in_month == MONTH_OCT) ? ZEL_OCT : ZEL_MAR;
        b_sum_next = LAST_DAY + zel_m + SUM_W'(yrem) + SUM_W'(yrem[REM_W-1:2])
                   + SUM_W'(up_data.cent[CENT_W-1:2]) + (SUM_W'(up_data.cent) << 2)
                   + SUM_W'(up_data.cent);
    end

    assign up_stall = b_valid_reg && b_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            b_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            b_item_reg <= up_data.item;
            b_sum_reg  <= b_sum_next;
        end
    end

    always_comb
    begin
        prod  = PROD_W'(b_sum_reg) * PROD_W'(DIV7_MUL);
        quo   = prod[PROD_W-1:DIV7_SHIFT];
        quo7  = (SUM_W'(quo) << 3) - SUM_W'(quo);
        rem_w = b_sum_reg - quo7;
        rem   = rem_w[2:0];
        // Zeller gives 0 = Saturday; rotate to 0 = Sunday
        wday  = (rem == 3'd0) ? 3'd6 : (rem - 3'd1);
        c_data_next.item     = b_item_reg;
        c_data_next.last_sun = MONTH_END - DAY_W'(wday);
    end

    assign b_stall = c_valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (!b_stall)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!b_stall && b_valid_reg)
        begin
            c_data_reg <= c_data_next;
        end
    end

    assign dn_valid = c_valid_reg;
    assign dn_data  = c_data_reg;
endmodule

// ----- src/eust_shift.sv -----
// Final pipeline stage: summer-time decision and one-hour shift into the output register.
// Depends on eust_pkg.
module eust_shift (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_stall,
    input  eust_pkg::sun_t    up_data,
    output logic              dn_valid,
    input  logic              dn_stall,
    output eust_pkg::result_t dn_data
);
    import eust_pkg::*;

    logic               valid_reg;
    result_t            data_reg;
    result_t            data_next;
    item_t              it;
    logic               summer;
    logic               mar_on;
    logic               oct_on;
    logic [DAY_W:0]     day_inc;
    logic [MONTH_W-1:0] prev_month;

    always_comb
    begin
        it         = up_data.item;
        mar_on     = (it.in_day > up_data.last_sun)
                   || ((it.in_day == up_data.last_sun) && (it.in_hour >= HOUR_SPRING));
        oct_on     = (it.in_day < up_data.last_sun)
                   || ((it.in_day == up_data.last_sun) && (it.in_hour < HOUR_AUTUMN));
        summer     = ((it.in_month >= MONTH_APR) && (it.in_month <= MONTH_SEP))
                   || ((it.in_month == MONTH_MAR) && mar_on)
                   || ((it.in_month == MONTH_OCT) && oct_on);
        day_inc    = {1'b0, it.in_day} + (DAY_W+1)'(1);
        prev_month = it.in_month - MONTH_W'(1);

        data_next.out_year    = it.in_year;
        data_next.out_month   = it.in_month;
        data_next.out_day     = it.in_day;
        data_next.out_hour    = it.in_hour;
        data_next.summer_time = summer;

        if (summer && !it.action)
        begin
            if (it.in_hour >= HOUR_MAX)
            begin
                data_next.out_hour = '0;
                if (day_inc > {1'b0, month_len(it.in_month)})
                begin
                    data_next.out_day   = DAY_W'(1);
                    data_next.out_month = it.in_month + MONTH_W'(1);
                end
                else
                begin
                    data_next.out_day = day_inc[DAY_W-1:0];
                end
            end
            else
            begin
                data_next.out_hour = it.in_hour + HOUR_W'(1);
            end
        end
        else if (summer && it.action)
        begin
            if (it.in_hour != '0)
            begin
                data_next.out_hour = it.in_hour - HOUR_W'(1);
            end
            else
            begin
                data_next.out_hour = HOUR_MAX;
                if (it.in_day > DAY_W'(1))
                begin
                    data_next.out_day = it.in_day - DAY_W'(1);
                end
                else
                begin
                    data_next.out_month = prev_month;
                    data_next.out_day   = month_len(prev_month);
                end
            end
        end
    end

    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;
endmodule

// ----- src/eu_summer_time_hour_shift.sv -----
// Top level of the EU summer-time hour shift: four-stage pipeline.
// Depends on eust_pkg, eust_century, eust_lastsun, eust_shift.
//
// Usage:
//   req channel (req_valid, req_stall, req): one date/hour item plus the
//   direction (action 0 adds an hour, 1 subtracts one, in summer time only).
//   rsp channel (rsp_valid, rsp_stall, rsp): the shifted date/hour and the
//   summer_time flag, one result per item, in order.
//   Throughput is one item per cycle while rsp_stall is low; the stages
//   are century split (reciprocal multiply), Zeller sum, mod 7 with
//   last-Sunday date, and decision/shift, in that order.
//   Each stage holds while its successor is full and stalled; an empty stage
//   fills even under stall, so up to four items are held before req_stall
//   rises. req_stall is combinational from rsp_stall and the stage valids.
//   Reset clears all stage valid bits; payload registers are not reset.
//   The year passes through unchanged; minutes and seconds are not handled.
module eu_summer_time_hour_shift (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  eust_pkg::item_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output eust_pkg::result_t rsp
);
    import eust_pkg::*;

    logic cen_valid;
    logic cen_stall;
    cen_t cen_data;
    logic sun_valid;
    logic sun_stall;
    sun_t sun_data;

    eust_century u_century (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_stall (req_stall),
        .up_item  (req),
        .dn_valid (cen_valid),
        .dn_stall (cen_stall),
        .dn_data  (cen_data)
    );

    eust_lastsun u_lastsun (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cen_valid),
        .up_stall (cen_stall),
        .up_data  (cen_data),
        .dn_valid (sun_valid),
        .dn_stall (sun_stall),
        .dn_data  (sun_data)
    );

    eust_shift u_shift (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sun_valid),
        .up_stall (sun_stall),
        .up_data  (sun_data),
        .dn_valid (rsp_valid),
        .dn_stall (rsp_stall),
        .dn_data  (rsp)
    );
endmodule

// ----- src/eust_checker.sv -----
// Port-level checks for the summer-time hour shift, bound to the top level.
// Depends on eust_pkg and eu_summer_time_hour_shift.
module eust_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input eust_pkg::item_t   req,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input eust_pkg::result_t rsp
);
    import eust_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("input stalled with empty output");

    a_summer_months: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.summer_time |-> (rsp.out_month >= MONTH_MAR)
                                         && (rsp.out_month <= MONTH_OCT))
        else $error("summer time outside March to October");

    a_core_summer: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.summer_time |-> !((rsp.out_month >= MONTH_APR)
                                            && (rsp.out_month <= MONTH_SEP)))
        else $error("April to September without summer time");
endmodule

bind eu_summer_time_hour_shift eust_checker u_eust_checker (.*);
